[rtl/slid_pkg.sv]
// shared types and constants for the sorted list block
`timescale 1ns / 1ps

package slid_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic                     en;
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

[rtl/slid_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps

interface slid_req_if import slid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface slid_rsp_if import slid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic [COUNT_OUT_W-1:0]   entry_count;
  logic signed [DATA_W-1:0] smallest_value;
  logic                     smallest_valid;

  modport source (output valid, output status, output entry_count,
                  output smallest_value, output smallest_valid, input ready);
  modport sink (input valid, input status, input entry_count,
                input smallest_value, input smallest_valid, output ready);
endinterface

[rtl/slid_cell.sv]
// one cell of the sorted row: holds one entry and shifts with its neighbors
`timescale 1ns / 1ps

module slid_cell import slid_pkg::*; (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic                     occ,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic                     left_flag,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic signed [DATA_W-1:0] entry_next,
  output logic                     flag,
  output logic                     match
);

  // insert: at or past the insert point; delete: at or past the first match
  always_comb begin
    case (cmd.op)
      OP_INSERT: flag = !occ || (entry > cmd.value);
      OP_DELETE: flag = occ && (entry >= cmd.value);
      default:   flag = 1'b0;
    endcase
  end

  assign match = occ && (entry == cmd.value);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      OP_INSERT: begin
        if (left_flag) begin
          entry_next = left_entry;
        end else if (flag) begin
          entry_next = cmd.value;
        end
      end
      OP_DELETE: begin
        if (flag) begin
          entry_next = right_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      entry <= entry_next;
    end
  end

endmodule

[rtl/sorted_list_insert_delete.sv]
// sorted list top level: row of cells, entry count and response register
// the response to an accepted item is registered and valid from the cycle after it is taken
// throughput: one item per cycle; every cell compares and shifts in the same cycle
// a new item is taken while the previous response is taken or absent
// reset clears the entry count and the response valid; cell contents are not reset
`timescale 1ns / 1ps

module sorted_list_insert_delete import slid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  slid_req_if.sink   req,
  slid_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic signed [DATA_W-1:0] entries_next [CAPACITY];
  logic [CAPACITY-1:0]      flags;
  logic [CAPACITY-1:0]      hits;
  logic [CAPACITY-1:0]      occ;
  cell_cmd_t                cmd;
  logic                     accept;
  logic                     full;
  logic                     found;
  status_t                  status_next;
  logic [EW-1:0]            count_ext;
  logic signed [DATA_W-1:0] head_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign found     = |hits;

  always_comb begin
    cmd.op    = req.operation;
    cmd.value = req.value;
    cmd.en    = accept && (((req.operation == OP_INSERT) && !full) ||
                           ((req.operation == OP_DELETE) && found));
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_entry;
    logic                     left_flag;
    logic signed [DATA_W-1:0] right_entry;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_flag  = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_flag  = flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[i]),
      .left_entry  (left_entry),
      .left_flag   (left_flag),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .entry_next  (entries_next[i]),
      .flag        (flags[i]),
      .match       (hits[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    case (req.operation)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CW'(1);
        end
      end
      default: status_next = ST_DONE;
    endcase
  end

  assign count_ext = EW'(count_next);
  assign head_next = cmd.en ? entries_next[0] : entries[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status_next;
      rsp.entry_count    <= count_ext[COUNT_OUT_W-1:0];
      rsp.smallest_valid <= (count_next != '0);
      rsp.smallest_value <= (count_next != '0) ? head_next : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (req.operation == OP_INSERT) && !full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_miss_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (req.operation == OP_DELETE) && !found |=>
      (count == $past(count)) && (rsp.status == ST_NOT_FOUND))
    else $error("failed delete changed the count");

  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.smallest_valid == (count != '0)))
    else $error("smallest valid disagrees with count");

endmodule

[tb/tb_sorted_list_insert_delete.sv]
// testbench for the sorted list block: directed and random inserts and deletes checked against a local list model
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;
  import slid_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [DATA_W-1:0] smallest;
    logic                     smallest_valid;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  slid_req_if req_if ();
  slid_rsp_if rsp_if ();

  sorted_list_insert_delete #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always #2 clk = ~clk;

  logic signed [DATA_W-1:0] model_list [CAPACITY];
  int                       model_count;
  list_result_t             pending_results [$];
  int                       mismatches;
  int                       idle_pct;
  int                       stall_pct;
  int                       quiet_cycles;

  function automatic list_result_t apply_list_op(op_t op, logic signed [DATA_W-1:0] v);
    list_result_t res;
    int           pos;
    res.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        pos = model_count;
        for (int i = 0; i < model_count; i++) begin
          if (model_list[i] > v) begin
            pos = i;
            break;
          end
        end
        for (int i = model_count; i > pos; i--) model_list[i] = model_list[i-1];
        model_list[pos] = v;
        model_count++;
      end
    end else begin
      pos = model_count;
      for (int i = 0; i < model_count; i++) begin
        if (model_list[i] == v) begin
          pos = i;
          break;
        end
      end
      if (pos >= model_count) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < model_count; i++) model_list[i] = model_list[i+1];
        model_count--;
      end
    end
    res.count          = model_count[COUNT_OUT_W-1:0];
    res.smallest_valid = (model_count > 0);
    res.smallest       = (model_count > 0) ? model_list[0] : '0;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] expv, logic [DATA_W-1:0] gotv);
    $display("%0t mismatch on %s: expected %h got %h", $time, field, expv, gotv);
    mismatches++;
  endtask

  task automatic send_item(op_t op, logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= v;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_results.push_back(apply_list_op(op, v));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(op_t op);
    int unsigned r;
    r = $urandom_range(99);
    if (op == OP_DELETE && model_count > 0 && r < 60)
      return model_list[$urandom_range(model_count - 1)];
    if (r < 80) return int'($urandom_range(16)) - 8;
    if (r < 88) return ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  task automatic test_directed();
    idle_pct  = 15;
    stall_pct = 15;
    // empty table, then the only entry removed
    send_item(OP_DELETE, 0);
    send_item(OP_INSERT, 42);
    send_item(OP_DELETE, 42);
    // extremes and duplicates
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 7);
    send_item(OP_INSERT, 7);
    send_item(OP_DELETE, 8);
    send_item(OP_DELETE, 7);
    // fill up, then overflow
    while (model_count < CAPACITY) send_item(OP_INSERT, $urandom);
    send_item(OP_INSERT, 3);
    send_item(OP_DELETE, 32'sh80000000);
    wait_drained();
  endtask

  task automatic test_random_mix(int n_items);
    int          insert_pct;
    op_t         op;
    int unsigned pct_sel;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) begin
        pct_sel    = $urandom_range(3);
        insert_pct = (pct_sel == 0) ? 20 : (pct_sel == 1) ? 50 : (pct_sel == 2) ? 80 : 95;
      end
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
      send_item(op, pick_value(op));
      if (n == n_items / 2) wait_drained();
    end
  endtask

  task automatic test_back_to_back(int n_items);
    idle_pct  = 0;
    stall_pct = 0;
    test_random_mix(n_items);
    idle_pct  = 15;
    stall_pct = 15;
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_rsp
    list_result_t exp_res;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", '0, rsp_if.smallest_value);
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.status !== exp_res.status)
          report_mismatch("status", exp_res.status, rsp_if.status);
        if (rsp_if.entry_count !== exp_res.count)
          report_mismatch("entry_count", exp_res.count, rsp_if.entry_count);
        if (rsp_if.smallest_value !== exp_res.smallest)
          report_mismatch("smallest_value", exp_res.smallest, rsp_if.smallest_value);
        if (rsp_if.smallest_valid !== exp_res.smallest_valid)
          report_mismatch("smallest_valid", exp_res.smallest_valid, rsp_if.smallest_valid);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    mismatches       = 0;
    quiet_cycles     = 0;
    model_count      = 0;
    idle_pct         = 15;
    stall_pct        = 15;
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_INSERT;
    req_if.value     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(1500);
    test_back_to_back(300);

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
